// ===== src/lprsbf_pkg.sv =====
// ----------------------------------------------------------------------------
// lprsbf_pkg
// Types, constants and the arctangent table of the lidar crop filter.
// ----------------------------------------------------------------------------
`default_nettype none
package lprsbf_pkg;

  localparam int MaxFramePointsDef = 1048576;
  localparam int CordicStagesDef   = 16;
  localparam int AtanTabLen        = 24;
  localparam int CorW              = 36;
  localparam int FifoDepth         = 4;
  localparam int KeptW             = 21;
  localparam int NumRegs           = 8;

  typedef enum logic [2:0] {
    REG_MIN_RANGE = 3'd0,
    REG_MAX_RANGE = 3'd1,
    REG_BOX_MIN_X = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MIN_Y = 3'd4,
    REG_BOX_MAX_Y = 3'd5,
    REG_SECTOR_A  = 3'd6,
    REG_SECTOR_B  = 3'd7
  } reg_idx_e;

  typedef enum logic {
    KIND_POINT = 1'b0,
    KIND_FRAME = 1'b1
  } kind_e;

  typedef struct packed {
    logic [31:0]        offset_time;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [7:0]         reflectivity;
    logic [7:0]         tag;
    logic [7:0]         line;
    logic               last_in_frame;
  } pt_in_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        out_offset_time;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [7:0]         out_reflectivity;
    logic [7:0]         out_tag;
    logic [7:0]         out_line;
    logic [KeptW-1:0]   kept_in_frame;
  } pt_out_t;

  typedef struct packed {
    logic [22:0]        min_range;
    logic [22:0]        max_range;
    logic signed [23:0] box_min_x;
    logic signed [23:0] box_max_x;
    logic signed [23:0] box_min_y;
    logic signed [23:0] box_max_y;
    logic [31:0]        sector_a;
    logic [31:0]        sector_b;
  } cfg_t;

  typedef struct packed {
    logic                   vld;
    logic signed [CorW-1:0] x;
    logic signed [CorW-1:0] y;
    logic [31:0]            acc;
    logic                   rng_ok;
    logic                   box_in;
    logic                   origin;
    pt_in_t                 pl;
  } cor_t;

  typedef struct packed {
    logic   keep;
    pt_in_t pl;
  } cls_t;

  function automatic logic [31:0] atan_ent(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/lprsbf_in_if.sv =====
// ----------------------------------------------------------------------------
// lprsbf_in_if
// Point input channel: valid, ready and one point.
// ----------------------------------------------------------------------------
`default_nettype none
interface lprsbf_in_if;
  import lprsbf_pkg::*;
  logic   valid;
  logic   ready;
  pt_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/lprsbf_out_if.sv =====
// ----------------------------------------------------------------------------
// lprsbf_out_if
// Result channel: valid, ready and one kept point or frame record.
// ----------------------------------------------------------------------------
`default_nettype none
interface lprsbf_out_if;
  import lprsbf_pkg::*;
  logic    valid;
  logic    ready;
  pt_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/lprsbf_fifo.sv =====
// ----------------------------------------------------------------------------
// lprsbf_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module lprsbf_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire lprsbf_pkg::cls_t   wr_data_i,
  output logic                    full_o,
  input  wire logic               rd_i,
  output logic                    empty_o,
  output lprsbf_pkg::cls_t        rd_data_o
);
  import lprsbf_pkg::*;

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);

  cls_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(FifoDepth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == PtrW'(FifoDepth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= (rp_q == PtrW'(FifoDepth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/lprsbf_front.sv =====
// ----------------------------------------------------------------------------
// lprsbf_front
// Accept points, run range, box and CORDIC angle checks, mark keep or drop.
// ----------------------------------------------------------------------------
`default_nettype none
module lprsbf_front #(
  parameter int CORDIC_STAGES = lprsbf_pkg::CordicStagesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lprsbf_pkg::cfg_t cfg_i,
  lprsbf_in_if.sink             pt_in,
  input  wire logic             q_full_i,
  output logic                  q_wr_o,
  output lprsbf_pkg::cls_t      q_data_o
);
  import lprsbf_pkg::*;

  localparam int N = CORDIC_STAGES;

  cor_t        stg_q [N+1];
  cor_t        nxt   [N];
  cor_t        ent;
  logic [47:0] xx_q, yy_q;
  logic [45:0] mn2_q, mx2_q;
  logic [48:0] r2;
  logic        en;
  logic signed [CorW-1:0] px, py;
  logic [31:0] pacc;
  logic [31:0] rnd;
  logic signed [15:0] ang, a_lo, a_hi, b_lo, b_hi;
  logic        sec_hit;

  assign en           = !(stg_q[N].vld && q_full_i);
  assign pt_in.ready  = en;

  always_comb begin
    px   = CorW'(pt_in.data.pos_x);
    py   = CorW'(pt_in.data.pos_y);
    pacc = 32'h0;
    if (pt_in.data.pos_x < 0) begin
      if (pt_in.data.pos_y >= 0) begin
        px   = CorW'(pt_in.data.pos_y);
        py   = -CorW'(pt_in.data.pos_x);
        pacc = 32'h40000000;
      end else begin
        px   = -CorW'(pt_in.data.pos_y);
        py   = CorW'(pt_in.data.pos_x);
        pacc = 32'hC0000000;
      end
    end
    ent.vld    = pt_in.valid;
    ent.x      = px <<< 8;
    ent.y      = py <<< 8;
    ent.acc    = pacc;
    ent.rng_ok = 1'b0;
    ent.box_in = (pt_in.data.pos_x >= cfg_i.box_min_x) && (pt_in.data.pos_x <= cfg_i.box_max_x)
              && (pt_in.data.pos_y >= cfg_i.box_min_y) && (pt_in.data.pos_y <= cfg_i.box_max_y);
    ent.origin = (pt_in.data.pos_x == '0) && (pt_in.data.pos_y == '0);
    ent.pl     = pt_in.data;
  end

  assign r2 = {1'b0, xx_q} + {1'b0, yy_q};

  always_comb begin
    for (int i = 0; i < N; i++) begin
      nxt[i] = stg_q[i];
      if (stg_q[i].y >= 0) begin
        nxt[i].x   = stg_q[i].x + (stg_q[i].y >>> i);
        nxt[i].y   = stg_q[i].y - (stg_q[i].x >>> i);
        nxt[i].acc = stg_q[i].acc + atan_ent(5'(i));
      end else begin
        nxt[i].x   = stg_q[i].x - (stg_q[i].y >>> i);
        nxt[i].y   = stg_q[i].y + (stg_q[i].x >>> i);
        nxt[i].acc = stg_q[i].acc - atan_ent(5'(i));
      end
    end
    nxt[0].rng_ok = !((r2 < {3'b0, mn2_q}) || (r2 > {3'b0, mx2_q}));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q  <= 48'(pt_in.data.pos_x * pt_in.data.pos_x);
      yy_q  <= 48'(pt_in.data.pos_y * pt_in.data.pos_y);
      mn2_q <= 46'(cfg_i.min_range * cfg_i.min_range);
      mx2_q <= 46'(cfg_i.max_range * cfg_i.max_range);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= N; i++) begin
        stg_q[i] <= '0;
      end
    end else if (en) begin
      stg_q[0] <= ent;
      for (int i = 0; i < N; i++) begin
        stg_q[i+1] <= nxt[i];
      end
    end
  end

  always_comb begin
    rnd     = stg_q[N].acc + 32'h00008000;
    ang     = stg_q[N].origin ? 16'sd0 : $signed(rnd[31:16]);
    a_lo    = $signed(cfg_i.sector_a[15:0]);
    a_hi    = $signed(cfg_i.sector_a[31:16]);
    b_lo    = $signed(cfg_i.sector_b[15:0]);
    b_hi    = $signed(cfg_i.sector_b[31:16]);
    sec_hit = ((ang >= a_lo) && (ang <= a_hi)) || ((ang >= b_lo) && (ang <= b_hi));
    q_data_o.keep = stg_q[N].rng_ok && !sec_hit && !stg_q[N].box_in;
    q_data_o.pl   = stg_q[N].pl;
    q_wr_o        = stg_q[N].vld && en;
  end
endmodule
`default_nettype wire

// ===== src/lprsbf_back.sv =====
// ----------------------------------------------------------------------------
// lprsbf_back
// Emit kept points and frame records, count kept points per frame.
// ----------------------------------------------------------------------------
`default_nettype none
module lprsbf_back #(
  parameter int MAX_FRAME_POINTS = lprsbf_pkg::MaxFramePointsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire lprsbf_pkg::cls_t q_data_i,
  output logic                  q_rd_o,
  lprsbf_out_if.source          pt_out
);
  import lprsbf_pkg::*;

  localparam int CntW = $clog2(MAX_FRAME_POINTS + 1);

  logic [CntW-1:0]       cnt_q, cnt_d, cnt_inc;
  logic [CntW+KeptW-1:0] cnt_ext;
  logic                  rec_q, rec_d;
  logic                  vld_q, vld_d;
  pt_out_t               out_q, out_d;
  logic                  can_load;

  assign can_load     = !vld_q || pt_out.ready;
  assign pt_out.valid = vld_q;
  assign pt_out.data  = out_q;

  always_comb begin
    cnt_inc = (cnt_q < CntW'(MAX_FRAME_POINTS)) ? cnt_q + 1'b1 : cnt_q;
    cnt_d   = cnt_q;
    rec_d   = rec_q;
    vld_d   = vld_q && !pt_out.ready;
    out_d   = out_q;
    q_rd_o  = 1'b0;
    cnt_ext = '0;
    if (!q_empty_i) begin
      if (q_data_i.keep && !rec_q) begin
        if (can_load) begin
          cnt_d   = cnt_inc;
          cnt_ext = {{KeptW{1'b0}}, cnt_inc};
          vld_d   = 1'b1;
          out_d.kind             = KIND_POINT;
          out_d.out_offset_time  = q_data_i.pl.offset_time;
          out_d.out_x            = q_data_i.pl.pos_x;
          out_d.out_y            = q_data_i.pl.pos_y;
          out_d.out_z            = q_data_i.pl.pos_z;
          out_d.out_reflectivity = q_data_i.pl.reflectivity;
          out_d.out_tag          = q_data_i.pl.tag;
          out_d.out_line         = q_data_i.pl.line;
          out_d.kept_in_frame    = cnt_ext[KeptW-1:0];
          if (q_data_i.pl.last_in_frame) begin
            rec_d = 1'b1;
          end else begin
            q_rd_o = 1'b1;
          end
        end
      end else if (q_data_i.pl.last_in_frame) begin
        if (can_load) begin
          cnt_ext = {{KeptW{1'b0}}, cnt_q};
          cnt_d   = '0;
          rec_d   = 1'b0;
          vld_d   = 1'b1;
          out_d   = '0;
          out_d.kind          = KIND_FRAME;
          out_d.kept_in_frame = cnt_ext[KeptW-1:0];
          q_rd_o  = 1'b1;
        end
      end else begin
        q_rd_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rec_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rec_q <= rec_d;
      vld_q <= vld_d;
    end
  end
endmodule
`default_nettype wire

// ===== src/lidar_point_range_sector_box_filter_core.sv =====
// ----------------------------------------------------------------------------
// lidar_point_range_sector_box_filter_core
// Lidar point crop filter: range, excluded sectors and robot body box.
// Throughput: one point per cycle unless the queue to the back end is full;
// a kept last point of a frame yields a point and then a frame record, both
// sent through the single output register.
// Reset: registers return to defaults, kept count clears, pipeline empties.
// ----------------------------------------------------------------------------
`default_nettype none
module lidar_point_range_sector_box_filter_core #(
  parameter int MAX_FRAME_POINTS = lprsbf_pkg::MaxFramePointsDef,
  parameter int CORDIC_STAGES    = lprsbf_pkg::CordicStagesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  lprsbf_in_if.sink        pt_in,
  lprsbf_out_if.source     pt_out
);
  import lprsbf_pkg::*;

  cfg_t cfg_q;
  cls_t q_wr_data, q_rd_data;
  logic q_wr, q_rd, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_range <= 23'd100;
      cfg_q.max_range <= 23'd20000;
      cfg_q.box_min_x <= -24'sd500;
      cfg_q.box_max_x <= 24'sd500;
      cfg_q.box_min_y <= -24'sd500;
      cfg_q.box_max_y <= 24'sd500;
      cfg_q.sector_a  <= 32'h80007FFF;
      cfg_q.sector_b  <= 32'h80007FFF;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MIN_RANGE: cfg_q.min_range <= cfg_data_i[22:0];
        REG_MAX_RANGE: cfg_q.max_range <= cfg_data_i[22:0];
        REG_BOX_MIN_X: cfg_q.box_min_x <= cfg_data_i[23:0];
        REG_BOX_MAX_X: cfg_q.box_max_x <= cfg_data_i[23:0];
        REG_BOX_MIN_Y: cfg_q.box_min_y <= cfg_data_i[23:0];
        REG_BOX_MAX_Y: cfg_q.box_max_y <= cfg_data_i[23:0];
        REG_SECTOR_A:  cfg_q.sector_a  <= cfg_data_i;
        REG_SECTOR_B:  cfg_q.sector_b  <= cfg_data_i;
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  lprsbf_front #(.CORDIC_STAGES(CORDIC_STAGES)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .pt_in    (pt_in),
    .q_full_i (q_full),
    .q_wr_o   (q_wr),
    .q_data_o (q_wr_data)
  );

  lprsbf_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .empty_o   (q_empty),
    .rd_data_o (q_rd_data)
  );

  lprsbf_back #(.MAX_FRAME_POINTS(MAX_FRAME_POINTS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rd_data),
    .q_rd_o    (q_rd),
    .pt_out    (pt_out)
  );
endmodule
`default_nettype wire
